// File: src/skts_pkg.sv
// ----------------------------------------------------------------------------
// skts_pkg
// Shared constants, codes and types of the sorted key table search block.
// ----------------------------------------------------------------------------
package skts_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 32;
   localparam int VALUE_W     = 32;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } wr_port_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_port_type;

   typedef struct packed {
      logic               valid;
      logic               found;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } result_type;

   // Midpoint of the window [lo, hix - 1]; valid only while lo < hix.
   function automatic logic [ADDR_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                                input logic [CNT_W-1:0] hix);
      logic [CNT_W:0] sum;
      sum = {1'b0, lo} + {1'b0, hix} - {{CNT_W{1'b0}}, 1'b1};
      return sum[ADDR_W:1];
   endfunction

endpackage

// File: src/sorted_key_table_search.sv
// ----------------------------------------------------------------------------
// sorted_key_table_search
// Sorted key and value table with a binary search lookup.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_stall   action, entry_key, entry_value
//  rsp      out        rsp_valid/rsp_stall   found, match_key, match_value
//
// A load or clear request is taken in the idle state. A lookup probes the
// key memory once per step of the search, at most about log2(depth) + 1
// probes, each through the registered memory read in the probe loop. Reset
// empties the table at once; the memories themselves are not cleared. While
// a response is stalled, loads, clears and one more lookup are still taken;
// a lookup that then finishes waits in the sequencer, and requests stall
// until the response is taken.
// ----------------------------------------------------------------------------
module sorted_key_table_search (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_action,
   input  logic [skts_pkg::KEY_W-1:0]   req_entry_key,
   input  logic [skts_pkg::VALUE_W-1:0] req_entry_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_found,
   output logic [skts_pkg::KEY_W-1:0]   rsp_match_key,
   output logic [skts_pkg::VALUE_W-1:0] rsp_match_value
);

   skts_pkg::wr_port_type        wr;
   skts_pkg::rd_port_type        rd;
   skts_pkg::result_type         res;
   logic [skts_pkg::KEY_W-1:0]   rd_key;
   logic [skts_pkg::VALUE_W-1:0] rd_value;
   logic                         res_ready;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff;
   logic [skts_pkg::KEY_W-1:0]   rsp_key_ff;
   logic [skts_pkg::VALUE_W-1:0] rsp_value_ff;

   skts_table u_table (
      .clock    (clock),
      .wr       (wr),
      .rd       (rd),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   skts_search u_search (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_entry_key   (req_entry_key),
      .req_entry_value (req_entry_value),
      .wr              (wr),
      .rd              (rd),
      .rd_key          (rd_key),
      .rd_value        (rd_value),
      .res_ready       (res_ready),
      .res             (res)
   );

   assign res_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res.valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res.valid) begin
         rsp_found_ff <= res.found;
         rsp_key_ff   <= res.key;
         rsp_value_ff <= res.value;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_key   = rsp_key_ff;
   assign rsp_match_value = rsp_value_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !res.valid)
      else $error("stalled response overwritten");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
      (rsp_valid_ff && $stable(rsp_key_ff) && $stable(rsp_value_ff)))
      else $error("stalled response changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_key_ff == '0 && rsp_value_ff == '0))
      else $error("miss response carries nonzero payload");

endmodule

// File: src/skts_table.sv
// ----------------------------------------------------------------------------
// skts_table
// Key and value storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module skts_table (
   input  logic                         clock,
   input  skts_pkg::wr_port_type        wr,
   input  skts_pkg::rd_port_type        rd,
   output logic [skts_pkg::KEY_W-1:0]   rd_key,
   output logic [skts_pkg::VALUE_W-1:0] rd_value
);

   logic [skts_pkg::KEY_W-1:0]   key_mem   [skts_pkg::TABLE_DEPTH];
   logic [skts_pkg::VALUE_W-1:0] value_mem [skts_pkg::TABLE_DEPTH];
   logic [skts_pkg::KEY_W-1:0]   rd_key_ff;
   logic [skts_pkg::VALUE_W-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr]   <= wr.key;
         value_mem[wr.addr] <= wr.value;
      end
      if (rd.en) begin
         rd_key_ff   <= key_mem[rd.addr];
         rd_value_ff <= value_mem[rd.addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

// File: src/skts_search.sv
// ----------------------------------------------------------------------------
// skts_search
// Request decode, entry count and the binary search sequencer.
// ----------------------------------------------------------------------------
module skts_search (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_action,
   input  logic [skts_pkg::KEY_W-1:0]   req_entry_key,
   input  logic [skts_pkg::VALUE_W-1:0] req_entry_value,
   output skts_pkg::wr_port_type        wr,
   output skts_pkg::rd_port_type        rd,
   input  logic [skts_pkg::KEY_W-1:0]   rd_key,
   input  logic [skts_pkg::VALUE_W-1:0] rd_value,
   input  logic                         res_ready,
   output skts_pkg::result_type         res
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SEARCH = 2'b10
   } state_type;

   state_type                        state_ff, state_in;
   logic [skts_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [skts_pkg::CNT_W-1:0]       lo_ff, lo_in;
   logic [skts_pkg::CNT_W-1:0]       hix_ff, hix_in;
   logic [skts_pkg::ADDR_W-1:0]      mid_ff, mid_in;
   logic                             empty_ff, empty_in;
   logic [skts_pkg::KEY_W-1:0]       key_ff, key_in;

   logic                             hit;
   logic                             less;
   logic [skts_pkg::CNT_W-1:0]       mid_ext;
   logic [skts_pkg::CNT_W-1:0]       lo_nx;
   logic [skts_pkg::CNT_W-1:0]       hix_nx;
   logic                             done;

   assign req_stall = (state_ff != ST_IDLE);
   assign mid_ext   = skts_pkg::CNT_W'(mid_ff);
   assign hit       = !empty_ff && (key_ff == rd_key);
   assign less      = key_ff < rd_key;
   assign lo_nx     = less ? lo_ff : (mid_ext + skts_pkg::CNT_W'(1));
   assign hix_nx    = less ? mid_ext : hix_ff;
   assign done      = empty_ff || hit || (lo_nx >= hix_nx);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hix_in    = hix_ff;
      mid_in    = mid_ff;
      empty_in  = empty_ff;
      key_in    = key_ff;
      wr.en     = 1'b0;
      wr.addr   = count_ff[skts_pkg::ADDR_W-1:0];
      wr.key    = req_entry_key;
      wr.value  = req_entry_value;
      rd.en     = 1'b0;
      rd.addr   = mid_ff;
      res.valid = 1'b0;
      res.found = hit;
      res.key   = hit ? rd_key : '0;
      res.value = hit ? rd_value : '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  skts_pkg::ACT_LOAD: begin
                     if (req_entry_key != '0 &&
                         count_ff < skts_pkg::CNT_W'(skts_pkg::TABLE_DEPTH)) begin
                        wr.en    = 1'b1;
                        count_in = count_ff + skts_pkg::CNT_W'(1);
                     end
                  end
                  skts_pkg::ACT_LOOKUP: begin
                     key_in   = req_entry_key;
                     lo_in    = '0;
                     hix_in   = count_ff;
                     empty_in = (count_ff == '0);
                     mid_in   = skts_pkg::mid_of('0, count_ff);
                     rd.en    = (count_ff != '0);
                     rd.addr  = mid_in;
                     state_in = ST_SEARCH;
                  end
                  skts_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (done) begin
               if (res_ready) begin
                  res.valid = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               lo_in   = lo_nx;
               hix_in  = hix_nx;
               mid_in  = skts_pkg::mid_of(lo_nx, hix_nx);
               rd.en   = 1'b1;
               rd.addr = mid_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      lo_ff    <= lo_in;
      hix_ff   <= hix_in;
      mid_ff   <= mid_in;
      empty_ff <= empty_in;
      key_ff   <= key_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= skts_pkg::CNT_W'(skts_pkg::TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_probe_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && !empty_ff) |->
      (lo_ff <= mid_ext && mid_ext < hix_ff && hix_ff <= count_ff))
      else $error("probe outside the search window");

   a_read_then_search: assert property (@(posedge clock) disable iff (reset)
      rd.en |=> (state_ff == ST_SEARCH))
      else $error("read data arrived outside a search");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == ST_IDLE && !rd.en))
      else $error("table write during a search");

endmodule
